[rtl/trpd_pkg.sv]
package trpd_pkg;

   localparam int PALETTE_DEPTH_DEFAULT = 256;

   localparam logic [2:0] CSR_RLE_ENABLE        = 3'd0;
   localparam logic [2:0] CSR_PIXEL_FORMAT      = 3'd1;
   localparam logic [2:0] CSR_BYTES_PER_PIXEL   = 3'd2;
   localparam logic [2:0] CSR_PALETTE_FIRST     = 3'd3;
   localparam logic [2:0] CSR_PALETTE_LENGTH    = 3'd4;
   localparam logic [2:0] CSR_PALETTE_HAS_ALPHA = 3'd5;
   localparam logic [2:0] CSR_PIXEL_TOTAL       = 3'd6;

   localparam logic FUNC_DATA    = 1'b0;
   localparam logic FUNC_PALETTE = 1'b1;

   localparam logic [1:0] FMT_TRUECOLOR = 2'd0;
   localparam logic [1:0] FMT_GRAYSCALE = 2'd1;
   localparam logic [1:0] FMT_PALETTE   = 2'd2;

   localparam logic ERR_NONE    = 1'b0;
   localparam logic ERR_PALETTE = 1'b1;

   localparam logic [6:0] RUN_LENGTH_MASK = 7'h7f;
   localparam logic [7:0] ALPHA_OPAQUE    = 8'd255;

   typedef struct packed {
      logic        rle_enable;
      logic [1:0]  pixel_format;
      logic [2:0]  bytes_per_pixel;
      logic [15:0] palette_first;
      logic [8:0]  palette_length;
      logic        palette_has_alpha;
      logic [31:0] pixel_total;
   } trpd_cfg_type;

   // A palette write carries its entry in data and its index in tag; a pixel
   // carries its stored bytes in data and its run length in tag.
   typedef struct packed {
      logic        is_write;
      logic [31:0] data;
      logic [7:0]  tag;
   } trpd_item_type;

endpackage

[rtl/trpd_ram.sv]
module trpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/trpd_front.sv]
module trpd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  trpd_pkg::trpd_cfg_type  cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    func,
   input  logic [7:0]              data_byte,
   input  logic [7:0]              entry_index,
   input  logic [31:0]             entry_rgba,
   input  logic                    queue_full,
   output logic                    push,
   output trpd_pkg::trpd_item_type push_item
);
   import trpd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_REPEAT,
      PH_LITERAL
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  remain_ff, remain_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [1:0]  pos_ff, pos_in;

   logic        accept;
   logic [2:0]  eff_bpp;
   logic [31:0] bytes_new;
   logic        last_byte;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;
   assign bytes_new = bytes_ff | (32'(data_byte) << {pos_ff, 3'b000});
   assign last_byte = ({1'b0, pos_ff} + 3'd1) >= eff_bpp;

   always_comb begin
      case (cfg.bytes_per_pixel)
         3'd0:                 eff_bpp = 3'd1;
         3'd1, 3'd2, 3'd3:     eff_bpp = cfg.bytes_per_pixel;
         default:              eff_bpp = 3'd4;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      bytes_in  = bytes_ff;
      pos_in    = pos_ff;
      push      = 1'b0;
      push_item = '{is_write: 1'b1, data: entry_rgba, tag: entry_index};
      if (accept) begin
         if (func == FUNC_PALETTE) begin
            push = 1'b1;
         end else if (cfg.rle_enable && phase_ff == PH_HEADER) begin
            remain_in = {1'b0, data_byte[6:0] & RUN_LENGTH_MASK};
            phase_in  = data_byte[7] ? PH_REPEAT : PH_LITERAL;
         end else if (!last_byte) begin
            bytes_in = bytes_new;
            pos_in   = pos_ff + 2'd1;
         end else begin
            push      = 1'b1;
            bytes_in  = '0;
            pos_in    = '0;
            push_item = '{is_write: 1'b0, data: bytes_new, tag: 8'd1};
            if (cfg.rle_enable) begin
               if (phase_ff == PH_REPEAT) begin
                  push_item.tag = remain_ff + 8'd1;
                  remain_in     = '0;
                  phase_in      = PH_HEADER;
               end else if (remain_ff == 8'd0) begin
                  phase_in = PH_HEADER;
               end else begin
                  remain_in = remain_ff - 8'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         remain_ff <= '0;
         bytes_ff  <= '0;
         pos_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         bytes_ff  <= bytes_in;
         pos_ff    <= pos_in;
      end
   end

`ifndef SYNTHESIS
   a_run_needs_rle : assert property (@(posedge clock) disable iff (reset)
      (push && !push_item.is_write && push_item.tag != 8'd1) |-> cfg.rle_enable)
      else $error("repeat run produced outside run-length mode");
`endif

endmodule

[rtl/trpd_queue.sv]
module trpd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  trpd_pkg::trpd_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    out_valid,
   output trpd_pkg::trpd_item_type out_item
);
   import trpd_pkg::*;

   localparam int DEPTH = 2;

   trpd_item_type entries_ff [DEPTH];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full      = count_ff == 2'(DEPTH);
   assign out_valid = count_ff != 2'd0;
   assign out_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop) && !(pop && !out_valid))
      else $error("queue pushed when full or popped when empty");
`endif

endmodule

[rtl/trpd_back.sv]
module trpd_back #(
   parameter int PALETTE_DEPTH = trpd_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  trpd_pkg::trpd_cfg_type  cfg,
   input  logic                    q_valid,
   input  trpd_pkg::trpd_item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              red,
   output logic [7:0]              green,
   output logic [7:0]              blue,
   output logic [7:0]              alpha,
   output logic [7:0]              repeat_count,
   output logic                    image_done,
   output logic                    error_code
);
   import trpd_pkg::*;

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [16:0] DEPTH_W = 17'(PALETTE_DEPTH);

   logic          valid_ff, valid_in;
   logic [31:0]   color_ff, color_in;
   logic          pal_ff, pal_in;
   logic          pal_alpha_ff, pal_alpha_in;
   logic [7:0]    cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic          err_ff, err_in;
   logic [31:0]   emitted_ff, emitted_in;
   logic          failed_ff, failed_in;

   logic          advance;
   logic          pixel;
   logic          active;
   logic [7:0]    b0;
   logic [7:0]    map;
   logic          bad;
   logic          is_pal;
   logic [31:0]   left;
   logic          take_all;
   logic [7:0]    cnt;
   logic          ram_we;
   logic          ram_re;
   logic [AW-1:0] ram_addr;
   logic [31:0]   ram_q;

   assign advance = !valid_ff || rsp_ready;
   assign q_pop   = advance && q_valid;
   assign pixel   = q_pop && !q_item.is_write;
   assign b0      = q_item.data[7:0];
   assign is_pal  = cfg.pixel_format == FMT_PALETTE;
   assign map     = (16'(b0) >= cfg.palette_first) ? b0 - cfg.palette_first[7:0] : b0;
   assign bad     = ({1'b0, map} >= cfg.palette_length) || ({9'b0, map} >= DEPTH_W);
   assign active  = emitted_ff < cfg.pixel_total;
   assign left    = cfg.pixel_total - emitted_ff;
   assign take_all = 32'(q_item.tag) < left;
   assign cnt     = take_all ? q_item.tag : left[7:0];

   assign ram_we   = q_pop && q_item.is_write && ({9'b0, q_item.tag} < DEPTH_W);
   assign ram_re   = pixel && is_pal && !bad;
   assign ram_addr = q_item.is_write ? AW'({9'b0, q_item.tag}) : AW'({9'b0, map});

   trpd_ram #(
      .WIDTH (32),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .rd_en   (ram_re),
      .addr    (ram_addr),
      .wr_data (q_item.data),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in     = valid_ff;
      color_in     = color_ff;
      pal_in       = pal_ff;
      pal_alpha_in = pal_alpha_ff;
      cnt_in       = cnt_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      emitted_in   = emitted_ff;
      failed_in    = failed_ff;
      if (advance) begin
         valid_in = pixel && active;
      end
      if (pixel && active) begin
         cnt_in       = cnt;
         done_in      = !take_all;
         err_in       = failed_ff;
         pal_in       = 1'b0;
         pal_alpha_in = cfg.palette_has_alpha;
         emitted_in   = emitted_ff + 32'(cnt);
         case (cfg.pixel_format)
            FMT_GRAYSCALE: begin
               color_in = {b0, b0, b0, ALPHA_OPAQUE};
            end
            FMT_PALETTE: begin
               color_in = '0;
               if (bad) begin
                  err_in    = ERR_PALETTE;
                  failed_in = 1'b1;
               end else begin
                  pal_in = 1'b1;
               end
            end
            default: begin
               color_in = {q_item.data[23:16], q_item.data[15:8], b0,
                           (cfg.bytes_per_pixel >= 3'd4) ? q_item.data[31:24]
                                                         : ALPHA_OPAQUE};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         emitted_ff <= '0;
         failed_ff  <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         emitted_ff <= emitted_in;
         failed_ff  <= failed_in;
      end
      color_ff     <= color_in;
      pal_ff       <= pal_in;
      pal_alpha_ff <= pal_alpha_in;
      cnt_ff       <= cnt_in;
      done_ff      <= done_in;
      err_ff       <= err_in;
   end

   assign rsp_valid    = valid_ff;
   assign red          = pal_ff ? ram_q[31:24] : color_ff[31:24];
   assign green        = pal_ff ? ram_q[23:16] : color_ff[23:16];
   assign blue         = pal_ff ? ram_q[15:8]  : color_ff[15:8];
   assign alpha        = pal_ff ? (pal_alpha_ff ? ram_q[7:0] : ALPHA_OPAQUE) : color_ff[7:0];
   assign repeat_count = cnt_ff;
   assign image_done   = done_ff;
   assign error_code   = err_ff;

`ifndef SYNTHESIS
   a_done_at_total : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> (emitted_ff == cfg.pixel_total))
      else $error("image done flagged before the pixel total was reached");
   a_count_nonzero : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cnt_ff != 8'd0))
      else $error("result carries a zero repeat count");
   a_error_sticky : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && failed_ff) |-> (err_ff == ERR_PALETTE))
      else $error("result lost the sticky palette error");
`endif

endmodule

[rtl/tga_rle_pixel_decoder.sv]
// TGA image-data decoder. Each request on the req_ channel is either one
// image-data byte or one palette entry write, selected by req_tuser. Bytes are
// split into run-length packets when rle_enable is set, assembled into stored
// pixels and converted to RGBA. Each finished pixel up to pixel_total leaves on
// the rsp_ channel with its repeat count; rsp_tlast marks the result that reaches
// pixel_total and rsp_tuser carries the sticky palette error.
// Configuration is written through the csr_ channel, which is always ready;
// the user must write it only while no request is in flight, which the block
// does not enforce. A completed pixel passes a two-entry queue and then a
// registered output stage before it appears on the rsp_ channel. One request
// is taken every cycle while results are taken; the palette memory port is
// shared by entry writes and index lookups, at most one access per request.
// Reset returns the packet parser and pixel counters to their start and the
// configuration registers to their defaults; palette contents stay undefined
// until written. When the receiver stalls the result is held, up to two more
// requests are queued and then req_tready falls until results drain.
module tga_rle_pixel_decoder #(
   parameter int PALETTE_DEPTH = trpd_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // data_byte, entry_index, entry_rgba
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // red, green, blue, alpha, repeat_count
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // error_code
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import trpd_pkg::*;

   trpd_cfg_type  cfg_ff, cfg_in;
   logic          push;
   trpd_item_type push_item;
   logic          queue_full;
   logic          pop;
   logic          q_valid;
   trpd_item_type q_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RLE_ENABLE:        cfg_in.rle_enable        = csr_data[0];
            CSR_PIXEL_FORMAT:      cfg_in.pixel_format      = csr_data[1:0];
            CSR_BYTES_PER_PIXEL:   cfg_in.bytes_per_pixel   = csr_data[2:0];
            CSR_PALETTE_FIRST:     cfg_in.palette_first     = csr_data[15:0];
            CSR_PALETTE_LENGTH:    cfg_in.palette_length    = csr_data[8:0];
            CSR_PALETTE_HAS_ALPHA: cfg_in.palette_has_alpha = csr_data[0];
            CSR_PIXEL_TOTAL:       cfg_in.pixel_total       = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rle_enable: 1'b0, pixel_format: FMT_TRUECOLOR,
                     bytes_per_pixel: 3'd4, palette_first: 16'd0,
                     palette_length: 9'd0, palette_has_alpha: 1'b0,
                     pixel_total: 32'd1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   trpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .func        (req_tuser),
      .data_byte   (req_tdata[7:0]),
      .entry_index (req_tdata[15:8]),
      .entry_rgba  (req_tdata[47:16]),
      .queue_full  (queue_full),
      .push        (push),
      .push_item   (push_item)
   );

   trpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .out_valid (q_valid),
      .out_item  (q_item)
   );

   trpd_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .red          (rsp_tdata[7:0]),
      .green        (rsp_tdata[15:8]),
      .blue         (rsp_tdata[23:16]),
      .alpha        (rsp_tdata[31:24]),
      .repeat_count (rsp_tdata[39:32]),
      .image_done   (rsp_tlast),
      .error_code   (rsp_tuser)
   );

endmodule
